/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/fhlc_pkg.sv */
// ----------------------------------------------------------------------------
// fhlc_pkg
// Shared types and constants of the frame header, length and checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fhlc_pkg;

    // Default largest frame, in bytes.
    localparam int MAX_FRAME_DEF = 1024;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 11;
    localparam int FRAME_LEN_W = 11;
    localparam int SUM_W       = 16;
    localparam int DECL_W      = 16;
    // Declared length plus overhead needs one bit more than the length field.
    localparam int TOTAL_W     = DECL_W + 1;

    // Frame format.
    localparam logic [BYTE_W-1:0]  SYNC_BYTE      = 8'h5A;
    localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = 17'd7;

    // Status codes of a closed frame.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SUM_ERR  = 3'd1,
        ST_SHORT    = 3'd2,
        ST_BAD_HDR  = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    // One received word as held in the input register.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              restart;
    } t_in_word;

    // One frame report.
    typedef struct packed {
        t_status                status;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [SUM_W-1:0]       computed_sum;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/fhlc_in_reg.sv */
// ----------------------------------------------------------------------------
// fhlc_in_reg
// Input register: holds one received word until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fhlc_in_reg
    import fhlc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_word,
    input  wire logic     i_take,
    output logic          o_valid,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;

    // The register frees up in the same cycle its word is taken.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Word payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fhlc_core.sv */
// ----------------------------------------------------------------------------
// fhlc_core
// Frame state and checks: counts bytes, tracks header and length, sums the
// frame and decides when a frame closes and with what status.
// ----------------------------------------------------------------------------
`default_nettype none

module fhlc_core
    import fhlc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_expected_size,
    input  wire logic             i_step,
    input  wire t_in_word         i_word,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_FRAME);

    // Frame state.
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_target;
    logic [SUM_W-1:0]  r_sum;
    logic [BYTE_W-1:0] r_recent0;
    logic [BYTE_W-1:0] r_recent1;
    logic              r_hdr_ok;
    logic [DECL_W-1:0] r_decl;

    logic [CW-1:0]      n_count;
    logic [CW-1:0]      n_target;
    logic [SUM_W-1:0]   n_sum;
    logic               n_hdr_ok;
    logic [DECL_W-1:0]  n_decl;

    logic [CW-1:0]      pos;
    logic               first;
    logic [CW-1:0]      cur_target;
    logic [SUM_W-1:0]   cur_sum;
    logic [BYTE_W-1:0]  cur_recent0;
    logic [BYTE_W-1:0]  cur_recent1;
    logic               cur_hdr_ok;
    logic [DECL_W-1:0]  cur_decl;
    logic [TOTAL_W-1:0] exp_ext;
    logic [TOTAL_W-1:0] exp_clamped;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] target_ext;
    logic [SUM_W-1:0]   check;
    logic               reached;
    logic               emit;
    logic               grow;
    t_status            status;

    // Position of this byte; a restart or a closed frame begins a new one.
    assign pos   = i_word.restart ? '0 : r_count;
    assign first = (pos == '0);

    // Expected size is clamped into the legal frame range.
    assign exp_ext = TOTAL_W'(i_expected_size);
    always_comb begin
        exp_clamped = exp_ext;
        if (exp_clamped < FRAME_OVERHEAD) begin
            exp_clamped = FRAME_OVERHEAD;
        end
        if (exp_clamped > MAX_TOTAL) begin
            exp_clamped = MAX_TOTAL;
        end
    end

    // State as seen by this byte, with a fresh frame on the first byte.
    assign cur_target  = first ? CW'(exp_clamped) : r_target;
    assign cur_sum     = first ? '0 : r_sum;
    assign cur_recent0 = first ? '0 : r_recent0;
    assign cur_recent1 = first ? '0 : r_recent1;
    assign cur_hdr_ok  = first ? 1'b1 : r_hdr_ok;
    assign cur_decl    = first ? '0 : r_decl;

    // Header, length field and running sum.
    always_comb begin
        n_hdr_ok = cur_hdr_ok;
        if (pos < CW'(2) && i_word.data_byte != SYNC_BYTE) begin
            n_hdr_ok = 1'b0;
        end
        n_decl = cur_decl;
        if (pos == CW'(3)) begin
            n_decl = {cur_decl[DECL_W-1:BYTE_W], i_word.data_byte};
        end
        if (pos == CW'(4)) begin
            n_decl = {i_word.data_byte, cur_decl[BYTE_W-1:0]};
        end
        // Bytes leave the two-byte delay line into the sum.
        n_sum = cur_sum;
        if (pos >= CW'(2)) begin
            n_sum = cur_sum + SUM_W'(cur_recent1);
        end
    end

    assign n_count    = pos + CW'(1);
    assign total      = TOTAL_W'(n_decl) + FRAME_OVERHEAD;
    assign target_ext = TOTAL_W'(cur_target);
    assign reached    = (n_count >= cur_target);
    assign check      = {i_word.data_byte, cur_recent0};

    // Once the target is met, close the frame or grow the target to the declared total.
    always_comb begin
        emit     = 1'b0;
        grow     = 1'b0;
        status   = ST_OK;
        n_target = cur_target;
        if (reached) begin
            if (!n_hdr_ok) begin
                emit   = 1'b1;
                status = ST_BAD_HDR;
            end else if (total > MAX_TOTAL) begin
                emit   = 1'b1;
                status = ST_TOO_LONG;
            end else if (total > target_ext) begin
                grow     = 1'b1;
                n_target = CW'(total);
            end else if (total < target_ext) begin
                emit   = 1'b1;
                status = ST_SHORT;
            end else begin
                emit   = 1'b1;
                status = (check == n_sum) ? ST_OK : ST_SUM_ERR;
            end
        end
    end

    assign o_res_valid         = i_step && emit;
    assign o_res.status        = status;
    assign o_res.frame_length  = FRAME_LEN_W'(n_count);
    assign o_res.computed_sum  = n_sum;

    // Byte counter; zero marks the start of the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= emit ? '0 : n_count;
        end
    end

    // Remaining frame state, only read while a frame is open.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_target  <= grow ? n_target : cur_target;
            r_sum     <= n_sum;
            r_recent1 <= cur_recent0;
            r_recent0 <= i_word.data_byte;
            r_hdr_ok  <= n_hdr_ok;
            r_decl    <= n_decl;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fhlc_out_reg.sv */
// ----------------------------------------------------------------------------
// fhlc_out_reg
// Result register: holds one frame report until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fhlc_out_reg
    import fhlc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Room for a new report when empty or when the held one leaves now.
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // Report payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/frame_header_length_checksum_check.sv */
// ----------------------------------------------------------------------------
// frame_header_length_checksum_check
// Frame checker for a byte stream: sync header, length field, 16-bit sum.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid / o_ready) carries one received byte per word
//   with a restart flag that drops any partial frame. The output channel
//   (o_valid / i_ready) carries one word per closed frame: status, length in
//   bytes and the computed sum. Most bytes produce no output word.
//   i_cfg_we writes the expected size; it is sampled at a frame's first byte.
//   Throughput is one byte per cycle unless the receiver stalls. A byte is
//   checked while it sits in the input register; a report it closes goes
//   into the result register as the byte is taken and is shown from there.
//   While the receiver stalls with a report waiting, no byte is checked: one
//   more byte fills the input register and then o_ready drops.
//   Reset empties both registers, sets the expected size to 7 and starts a
//   new frame with the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_header_length_checksum_check
    import fhlc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [BYTE_W-1:0]      i_data_byte,
    input  wire logic                   i_restart,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_status,
    output logic [FRAME_LEN_W-1:0]      o_frame_length,
    output logic [SUM_W-1:0]            o_computed_sum
);

    logic [CFG_W-1:0] r_expected_size;
    t_in_word         in_word;
    t_in_word         stg_word;
    logic             stg_valid;
    logic             step;
    logic             res_valid;
    t_result          res;
    t_result          out_res;
    logic             out_space;

    // Expected size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_size <= CFG_W'(FRAME_OVERHEAD);
        end else if (i_cfg_we) begin
            r_expected_size <= i_cfg_data;
        end
    end

    assign in_word.data_byte = i_data_byte;
    assign in_word.restart   = i_restart;

    // A held byte is checked when its possible report has somewhere to go.
    assign step = stg_valid && out_space;

    fhlc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (in_word),
        .i_take  (step),
        .o_valid (stg_valid),
        .o_word  (stg_word)
    );

    fhlc_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_expected_size (r_expected_size),
        .i_step          (step),
        .i_word          (stg_word),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    fhlc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_status       = out_res.status;
    assign o_frame_length = out_res.frame_length;
    assign o_computed_sum = out_res.computed_sum;

endmodule

`default_nettype wire

/* hw/rtl/fhlc_checker.sv */
// ----------------------------------------------------------------------------
// fhlc_checker
// Port-level checks of the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fhlc_checker
    import fhlc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [2:0]             o_status,
    input wire logic [FRAME_LEN_W-1:0] o_frame_length,
    input wire logic [SUM_W-1:0]       o_computed_sum
);

    // A stalled report keeps its contents.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_frame_length) && $stable(o_computed_sum), "stalled report changed")

    // Only defined status codes leave the block.
    `ASSERT_CLK(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status <= ST_TOO_LONG), "undefined status code")

    // Every frame closes at or after the minimum frame size.
    `ASSERT_CLK(a_min_length, i_clk, i_rst_n, o_valid |-> (o_frame_length >= FRAME_LEN_W'(FRAME_OVERHEAD)), "frame shorter than overhead")

    // Reset leaves no report behind.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "report valid after reset")

endmodule

bind frame_header_length_checksum_check fhlc_checker u_fhlc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_frame_length (o_frame_length),
    .o_computed_sum (o_computed_sum)
);

`default_nettype wire
